// ===== sv/fed_pkg.sv =====
// Shared constants for the feedback echo delay block.
`default_nettype none
package fed_pkg;
    localparam int DELAY_W    = 15;
    localparam int GAIN_W     = 16;
    localparam int FRAC_W     = 15;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_DELAY  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE = 2'd2;
endpackage
`default_nettype wire

// ===== sv/feedback_echo_delay_top.sv =====
// Feedback echo delay: tap address, ring store, gain/sum stages, output register.
// Words pass the first stage, second stage and output register at one word per cycle
// while the output is not stalled; the ring read, multiply and write-back are pipelined.
// Ring reads of entries not yet written return zero through a fill flag; no clearing pass.
// Reset clears the configuration registers, write pointer, fill flag and stage valids.
`default_nettype none
module feedback_echo_delay_top #(
    parameter int BUFFER_DEPTH = 65536,
    parameter int CHANNELS     = 2,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [fed_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  wire logic [fed_pkg::CFG_W-1:0]             cfg_data,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // sample_in
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    output logic      [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_axis_tdata   // sample_out
);
    import fed_pkg::*;

    localparam int SW  = SAMPLE_WIDTH;
    localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam int CW  = ((AW > DELAY_W + 4) ? AW : DELAY_W + 4) + 1;

    logic [DELAY_W-1:0]  delay_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic                on_reg;

    logic [AW-1:0]       wp_reg, wp_next;
    logic                filled_reg, filled_next;

    logic                s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic signed [SW-1:0] s1_x_reg;
    logic                s1_en_reg, s1_zero_reg, s1_fwd_reg;
    logic [AW-1:0]       s1_waddr_reg;
    logic signed [SW-1:0] s1_fwd_data_reg;
    logic                s2_en_reg;
    logic [AW-1:0]       s2_waddr_reg;
    logic [SW-1:0]       out_data_reg;

    logic                out_free, s2_free, s1_free;
    logic                s2_move, s1_move, accept;
    logic [CW-1:0]       off_full, off_clamp;
    logic [AW-1:0]       off;
    logic [AW:0]         rd_ext;
    logic [AW-1:0]       rd_addr;
    logic                rd_zero, rd_fwd;
    logic signed [SW-1:0] x_in;
    logic signed [SW-1:0] tap;
    logic signed [SW-1:0] mix_result;
    logic [SW-1:0]       ring_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= '0;
            gain_reg  <= '0;
            on_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_DELAY:  delay_reg <= cfg_data[DELAY_W-1:0];
                CFG_GAIN:   gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_ENABLE: on_reg    <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s2_move       = s2_valid_reg && out_free;
    assign s2_free       = !s2_valid_reg || out_free;
    assign s1_move       = s1_valid_reg && s2_free;
    assign s1_free       = !s1_valid_reg || s2_free;
    assign s_axis_tready = s1_free;
    assign accept        = s_axis_tvalid && s1_free;
    assign x_in          = s_axis_tdata[SW-1:0];

    always_comb
    begin
        off_full = CW'(delay_reg) * CW'(CHANNELS);
        if (off_full < CW'(2))
        begin
            off_clamp = CW'(2);
        end
        else if (off_full > CW'(BUFFER_DEPTH - 2))
        begin
            off_clamp = CW'(BUFFER_DEPTH - 2);
        end
        else
        begin
            off_clamp = off_full;
        end
        off = off_clamp[AW-1:0];
        if (wp_reg >= off)
        begin
            rd_ext = {1'b0, wp_reg} - {1'b0, off};
        end
        else
        begin
            rd_ext = {1'b0, wp_reg} + (AW+1)'(BUFFER_DEPTH) - {1'b0, off};
        end
        rd_addr = rd_ext[AW-1:0];
        rd_zero = !(filled_reg || (rd_addr < wp_reg));
        rd_fwd  = s2_valid_reg && s2_en_reg && (s2_waddr_reg == rd_addr);

        wp_next     = wp_reg;
        filled_next = filled_reg;
        if (accept && on_reg)
        begin
            if (wp_reg == AW'(BUFFER_DEPTH - 1))
            begin
                wp_next     = '0;
                filled_next = 1'b1;
            end
            else
            begin
                wp_next = wp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            filled_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg     <= wp_next;
            filled_reg <= filled_next;
            if (s1_free)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_move;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_move;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg        <= x_in;
            s1_en_reg       <= on_reg;
            s1_waddr_reg    <= wp_reg;
            s1_zero_reg     <= rd_zero;
            s1_fwd_reg      <= rd_fwd;
            s1_fwd_data_reg <= mix_result;
        end
        if (s1_move)
        begin
            s2_en_reg    <= s1_en_reg;
            s2_waddr_reg <= s1_waddr_reg;
        end
        if (s2_move)
        begin
            out_data_reg <= mix_result;
        end
    end

    always_comb
    begin
        if (s1_fwd_reg)
        begin
            tap = s1_fwd_data_reg;
        end
        else if (s1_zero_reg)
        begin
            tap = '0;
        end
        else
        begin
            tap = ring_rdata;
        end
    end

    fed_ring #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW),
        .DW    (SW)
    ) u_ring (
        .clk   (clk),
        .we    (s2_move && s2_en_reg),
        .waddr (s2_waddr_reg),
        .wdata (mix_result),
        .re    (accept && on_reg),
        .raddr (rd_addr),
        .rdata (ring_rdata)
    );

    fed_mix #(
        .SW (SW)
    ) u_mix (
        .clk    (clk),
        .load   (s1_move),
        .en     (s2_en_reg),
        .gain   (gain_reg),
        .tap    (tap),
        .x_in   (s1_x_reg),
        .result (mix_result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDW'(out_data_reg);

`ifndef SYNTHESIS
    a_wp_only_on_word: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && on_reg) |=> $stable(wp_reg))
        else $error("write pointer moved without an echoed word");

    a_distinct_waddr: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && s1_en_reg && s2_en_reg)
            |-> (s1_waddr_reg != s2_waddr_reg))
        else $error("two in-flight words share a ring address");

    a_fwd_needs_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_fwd_reg) |-> s1_en_reg)
        else $error("forwarded tap on a pass-through word");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted word lost before first stage");
`endif
endmodule
`default_nettype wire

// ===== sv/fed_ring.sv =====
// Ring store: single write port, one registered read port.
`default_nettype none
module fed_ring #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int DW    = 16
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ===== sv/fed_mix.sv =====
// Gain multiply stage and saturating add of the echo to the dry sample; the dry sample alone when en is low.
`default_nettype none
module fed_mix #(
    parameter int SW = 16
) (
    input  wire logic                        clk,
    input  wire logic                        load,
    input  wire logic                        en,
    input  wire logic [fed_pkg::GAIN_W-1:0]  gain,
    input  wire logic signed [SW-1:0]        tap,
    input  wire logic signed [SW-1:0]        x_in,
    output logic signed [SW-1:0]             result
);
    import fed_pkg::*;

    localparam int PW = SW + GAIN_W + 1;

    logic signed [PW-1:0]     prod_reg;
    logic signed [SW-1:0]     x_reg;
    logic signed [GAIN_W:0]   gain_s;
    logic signed [PW-1:0]     prod_next;
    logic signed [PW-1:0]     prod_sh;
    logic signed [SW+1:0]     sum_w;
    logic signed [SW-1:0]     sat;

    assign gain_s    = {1'b0, gain};
    assign prod_next = PW'(gain_s) * PW'(tap);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
            x_reg    <= x_in;
        end
    end

    always_comb
    begin
        prod_sh = prod_reg >>> FRAC_W;
        sum_w   = (SW+2)'(x_reg) + (SW+2)'(prod_sh);
        if (sum_w[SW+1:SW-1] == 3'b000 || sum_w[SW+1:SW-1] == 3'b111)
        begin
            sat = sum_w[SW-1:0];
        end
        else if (sum_w[SW+1])
        begin
            sat = {1'b1, {(SW-1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(SW-1){1'b1}}};
        end
        result = en ? sat : x_reg;
    end
endmodule
`default_nettype wire

// ===== verif/feedback_echo_delay_top_tb.sv =====
// Testbench for feedback_echo_delay_top: predicts every echoed word and checks the output stream.
`timescale 1ns / 1ps
module feedback_echo_delay_top_tb;
    import fed_pkg::*;

    localparam int RING_DEPTH   = 65536;
    localparam int NUM_CH       = 2;
    localparam int SW           = 16;
    localparam int DW           = ((SW + 7) / 8) * 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;
    localparam longint SMP_MAX  = 32767;
    localparam longint SMP_MIN  = -32768;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [DW-1:0]         s_axis_tdata;   // sample_in
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [DW-1:0]         m_axis_tdata;   // sample_out

    // echo model state
    logic signed [SW-1:0]  echo_ring [0:RING_DEPTH-1];
    logic [15:0]           ring_wr_ptr;
    logic [DELAY_W-1:0]    fx_delay;
    logic [GAIN_W-1:0]     fx_gain;
    logic                  fx_on;
    logic [SW-1:0]         expected_samples [$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    bit  tx_idle_en = 1'b1;
    bit  rx_idle_en = 1'b1;
    bit  hold_req = 1'b0;
    int  stall_cnt = 0;

    feedback_echo_delay_top #(
        .BUFFER_DEPTH (RING_DEPTH),
        .CHANNELS     (NUM_CH),
        .SAMPLE_WIDTH (SW)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d words outstanding", $time, expected_samples.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_cnt > 0)
                stall_cnt = stall_cnt - 1;
            else if (hold_req)
            begin
                stall_cnt = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 4) == 0)
                stall_cnt = $urandom_range(1, 8);
            m_axis_tready <= (stall_cnt == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_samples.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected word, expected none got %0d",
                         $time, $signed(m_axis_tdata[SW-1:0]));
            end
            else
            begin
                if (m_axis_tdata[SW-1:0] !== expected_samples[0])
                begin
                    mismatch_count++;
                    $display("%0t: sample_out expected %0d got %0d", $time,
                             $signed(expected_samples[0]), $signed(m_axis_tdata[SW-1:0]));
                end
                void'(expected_samples.pop_front());
            end
        end
    end

    task automatic predict_echo(input logic signed [SW-1:0] x);
        int                   offset;
        logic [15:0]          tap_idx;
        longint               prod;
        longint               sum;
        if (!fx_on)
        begin
            expected_samples.push_back(x);
            return;
        end
        offset = int'(fx_delay) * NUM_CH;
        if (offset < 2)
            offset = 2;
        if (offset > RING_DEPTH - 2)
            offset = RING_DEPTH - 2;
        tap_idx = ring_wr_ptr - offset[15:0];
        prod = longint'(fx_gain) * longint'(echo_ring[tap_idx]);
        sum = longint'(x) + (prod >>> FRAC_W);
        if (sum > SMP_MAX)
            sum = SMP_MAX;
        if (sum < SMP_MIN)
            sum = SMP_MIN;
        echo_ring[ring_wr_ptr] = sum[SW-1:0];
        ring_wr_ptr = ring_wr_ptr + 16'd1;
        expected_samples.push_back(sum[SW-1:0]);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DELAY:  fx_delay = val[DELAY_W-1:0];
            CFG_GAIN:   fx_gain  = val[GAIN_W-1:0];
            CFG_ENABLE: fx_on    = val[0];
            default:    ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_word(input logic signed [SW-1:0] x);
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_echo(x);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SW-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 63) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // effect off after reset, plus ignored and over-wide register writes
    task automatic test_passthrough();
        write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(CFG_ENABLE, 16'hFFFE);
        send_word(16'h0000);
        send_word(16'h7FFF);
        send_word(16'h8000);
        send_word(16'hFFFF);
        send_word(16'h0001);
        send_word(16'h5555);
        send_word(16'hAAAA);
        wait_idle();
    endtask

    // short delay clamp, unity and above-unity gain, saturation both ways
    task automatic test_echo_extremes();
        write_reg(CFG_DELAY, 16'h0000);
        write_reg(CFG_GAIN, 16'h8000);
        write_reg(CFG_ENABLE, 16'h0001);
        repeat (4) send_word(16'h7FFF);
        repeat (4) send_word(16'h8000);
        wait_idle();
        write_reg(CFG_GAIN, 16'hFFFF);
        send_word(16'hFFFF);
        send_word(16'h0001);
        send_word(16'h4000);
        send_word(16'hC000);
        wait_idle();
    endtask

    // longest delay, at the upper bound, then effect off leaves the ring and pointer alone
    task automatic test_long_delay_and_bypass();
        write_reg(CFG_DELAY, 16'hFFFF);
        write_reg(CFG_GAIN, 16'h8000);
        send_word(16'h1234);
        send_word(16'h8001);
        send_word(16'h7FFE);
        wait_idle();
        write_reg(CFG_DELAY, 16'h0001);
        write_reg(CFG_ENABLE, 16'h0000);
        send_word(16'h2222);
        send_word(16'hDDDD);
        wait_idle();
        write_reg(CFG_ENABLE, 16'h0001);
        send_word(16'h0100);
        wait_idle();
    endtask

    // receiver holds off while the sender keeps offering words
    task automatic test_backpressure();
        write_reg(CFG_DELAY, 16'h0003);
        write_reg(CFG_GAIN, 16'h6000);
        write_reg(CFG_ENABLE, 16'h0001);
        tx_idle_en = 1'b0;
        hold_req = 1'b1;
        repeat (40) send_word(rand_sample());
        wait_idle();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_random_phases();
        logic [DELAY_W-1:0] dly;
        logic [GAIN_W-1:0]  gain;
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 5)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            case ($urandom_range(0, 5))
                0:       dly = '0;
                1:       dly = '1;
                2:       dly = 15'($urandom_range(1, 8));
                3:       dly = 15'($urandom_range(9, 300));
                default: dly = 15'($urandom_range(1, 40));
            endcase
            case ($urandom_range(0, 5))
                0:       gain = 16'h0000;
                1:       gain = 16'h8000;
                2:       gain = 16'hFFFF;
                default: gain = 16'($urandom);
            endcase
            write_reg(CFG_DELAY, {1'($urandom), dly});
            write_reg(CFG_GAIN, gain);
            write_reg(CFG_ENABLE, {15'($urandom), 1'($urandom_range(0, 4) != 0)});
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_UNUSED, 16'($urandom));
            repeat (72) send_word(rand_sample());
            wait_idle();
        end
    endtask

    initial
    begin
        for (int i = 0; i < RING_DEPTH; i++)
            echo_ring[i] = '0;
        ring_wr_ptr   = '0;
        fx_delay      = '0;
        fx_gain       = '0;
        fx_on         = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_passthrough();
        test_echo_extremes();
        test_long_delay_and_bypass();
        test_backpressure();
        test_random_phases();

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
